// File: rtl/horizontal_box_blur_top_defines.svh
// Assertion macros used by the checker file of the box blur block.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef HORIZONTAL_BOX_BLUR_TOP_DEFINES_SVH
`define HORIZONTAL_BOX_BLUR_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define HBB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hbb check failed");

// Next-cycle implication, off while reset is high
`define HBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hbb check failed");

// Condition that must hold in the cycle after reset is sampled high
`define HBB_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("hbb check failed");

`endif

// File: rtl/hbb_pkg.sv
`default_nettype none

package hbb_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 16;

   // Fixed field widths on the ports
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 16;
   localparam int ROW_WIDTH_BITS = 11;
   localparam int RADIUS_BITS    = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_IDX_BITS   = 1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_WIDTH   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLUR_RADIUS = 1'd1;

   // Register reset values and width clamp floor
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RST   = 11'd1024;
   localparam logic [RADIUS_BITS-1:0]    BLUR_RADIUS_RST = 2'd1;
   localparam int                        MIN_WIDTH       = 5;

   // Window taps (radius 2 on both sides of the center)
   localparam int NUM_TAPS = 5;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

   // Divisor = number of taps kept in the clipped window
   typedef enum logic [1:0] {
      DIV_BY_2,
      DIV_BY_3,
      DIV_BY_4,
      DIV_BY_5
   } div_type;

   // Sideband flags that ride along with each result
   typedef struct packed {
      logic row_end;
      logic last_of_run;
   } tag_type;

   // One queued result
   typedef struct packed {
      logic [RSP_DATA_BITS-1:0] pixel;
      tag_type                  tag;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/hbb_tap_cell.sv
`default_nettype none

// One window tap: holds a pixel, hands it to the next tap on a shift and
// adds it into the running prefix sum when selected.
module hbb_tap_cell #(
   parameter int PIXEL_BITS = hbb_pkg::PIXEL_BITS_DEF,
   parameter int SUM_BITS   = hbb_pkg::PIXEL_BITS_DEF + 3
) (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire logic [PIXEL_BITS-1:0] prev_pix,
   output logic      [PIXEL_BITS-1:0] pix_q,
   input  wire logic                  use_tap,
   input  wire logic [SUM_BITS-1:0]   sum_prev,
   output logic      [SUM_BITS-1:0]   sum_next
);
   import hbb_pkg::*;

   logic [PIXEL_BITS-1:0] pix_ff;
   logic [PIXEL_BITS-1:0] pix_in;

   // Shift in from the neighbor on every accepted pixel
   always_comb begin
      pix_in = shift_en ? prev_pix : pix_ff;
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_q = pix_ff;

   // Prefix sum link
   assign sum_next = sum_prev + (use_tap ? SUM_BITS'(pix_ff) : '0);

endmodule

`default_nettype wire

// File: rtl/hbb_divider.sv
`default_nettype none

// Divides a window sum by 2..5. Powers of two are shifts; 3 and 5 use a
// rounded-up reciprocal, exact for every sum below 2**SumBits.
module hbb_divider #(
   parameter int PIXEL_BITS = hbb_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic [PIXEL_BITS+2:0]               in_sum,
   input  wire hbb_pkg::div_type                    in_div,
   input  wire hbb_pkg::tag_type                    in_tag,
   output logic                                     out_valid,
   output logic      [hbb_pkg::RSP_DATA_BITS-1:0]   out_pixel,
   output hbb_pkg::tag_type                         out_tag
);
   import hbb_pkg::*;

   localparam int SumBits   = PIXEL_BITS + 3;
   localparam int Shift     = SumBits + 2;
   localparam int RecipBits = Shift - 1;
   localparam int ProdBits  = SumBits + RecipBits;
   localparam int Recip3    = ((1 << Shift) + 2) / 3;
   localparam int Recip5    = ((1 << Shift) + 4) / 5;

   logic [RecipBits-1:0]  recip;
   logic [ProdBits-1:0]   prod;
   logic [PIXEL_BITS-1:0] quot;

   logic                     valid_ff;
   logic                     valid_in;
   logic [RSP_DATA_BITS-1:0] pixel_ff;
   logic [RSP_DATA_BITS-1:0] pixel_in;
   tag_type                  tag_ff;
   tag_type                  tag_in;

   // Reciprocal multiply, quotient in the upper product bits
   assign recip = (in_div == DIV_BY_5) ? RecipBits'(Recip5) : RecipBits'(Recip3);
   assign prod  = ProdBits'(in_sum) * ProdBits'(recip);

   always_comb begin
      case (in_div)
         DIV_BY_2: quot = in_sum[1 +: PIXEL_BITS];
         DIV_BY_4: quot = in_sum[2 +: PIXEL_BITS];
         DIV_BY_3: quot = prod[Shift +: PIXEL_BITS];
         DIV_BY_5: quot = prod[Shift +: PIXEL_BITS];
         default:  quot = in_sum[1 +: PIXEL_BITS];
      endcase
      valid_in = in_valid;
      pixel_in = RSP_DATA_BITS'(quot);
      tag_in   = in_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      tag_ff   <= tag_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

// File: rtl/hbb_out_fifo.sv
`default_nettype none

// Small result queue; the fill level goes back to the issue logic as credit.
module hbb_out_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push_valid,
   input  wire hbb_pkg::result_type              push_data,
   output logic                                  pop_valid,
   input  wire logic                             pop_ready,
   output hbb_pkg::result_type                   pop_data,
   output logic      [hbb_pkg::LEVEL_BITS-1:0]   level
);
   import hbb_pkg::*;

   result_type            entries_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [LEVEL_BITS-1:0] level_in;
   logic                  pop;

   assign pop = pop_ready && (level_ff != '0);

   // Pointer and level update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      level_in  = level_ff + LEVEL_BITS'(push_valid) - LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (level_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

`default_nettype wire

// File: rtl/horizontal_box_blur_top.sv
// Channel   Dir  Ports                       Payload
// req       in   req_tvalid/tready/tdata     tdata[15:0] pixel_in
// rsp       out  rsp_tvalid/tready/tdata     tdata[15:0] pixel_out, tlast row_end,
//                rsp_tlast/tuser             tuser last_of_run
// csr       in   csr_we/index/wdata          index 0 row_width, 1 blur_radius
//
// One pixel per clock while results can issue; the last pixel of a row holds req_tready
// low while its r+1 results (r = radius) issue through the single sum chain.
// A result is registered in the tap sum, divide and queue stages on its way from issue to rsp.
// The four-entry result queue absorbs rsp stalls; a full queue stops issue.
// Reset is synchronous: column, pending results and queue clear, registers load
// row_width 1024 and blur_radius 1.
`default_nettype none

module horizontal_box_blur_top #(
   parameter int MAX_WIDTH  = hbb_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = hbb_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_we,
   input  wire logic [hbb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [hbb_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // input pixels
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [hbb_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // [15:0] pixel_in
   // results
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [hbb_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // [15:0] pixel_out
   output logic                                      rsp_tlast,  // row_end
   output logic                                      rsp_tuser   // [0] last_of_run
);
   import hbb_pkg::*;

   localparam int SumBits = PIXEL_BITS + 3;
   localparam int CntBits = $clog2(MAX_WIDTH);
   localparam int WidBits = $clog2(MAX_WIDTH + 1);
   localparam int CmpBits = (WidBits > ROW_WIDTH_BITS) ? WidBits : ROW_WIDTH_BITS;

   // Configuration registers
   logic [ROW_WIDTH_BITS-1:0] row_width_ff;
   logic [ROW_WIDTH_BITS-1:0] row_width_in;
   logic [RADIUS_BITS-1:0]    radius_ff;
   logic [RADIUS_BITS-1:0]    radius_in;

   always_comb begin
      row_width_in = row_width_ff;
      radius_in    = radius_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_WIDTH:   row_width_in = csr_wdata[ROW_WIDTH_BITS-1:0];
            CSR_BLUR_RADIUS: radius_in    = csr_wdata[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RST;
         radius_ff    <= BLUR_RADIUS_RST;
      end else begin
         row_width_ff <= row_width_in;
         radius_ff    <= radius_in;
      end
   end

   // Column tracking and row end detection
   logic [CntBits-1:0] col_ff;
   logic [CntBits-1:0] col_in;
   logic [CmpBits-1:0] row_w;
   logic [CmpBits-1:0] eff_w;
   logic [1:0]         radius;
   logic               row_last;
   logic               col_ge_r;
   logic               accept;

   assign radius = radius_ff[1] ? 2'd2 : 2'd1;
   assign row_w  = CmpBits'(row_width_ff);

   always_comb begin
      if (row_w < CmpBits'(MIN_WIDTH)) begin
         eff_w = CmpBits'(MIN_WIDTH);
      end else if (row_w > CmpBits'(MAX_WIDTH)) begin
         eff_w = CmpBits'(MAX_WIDTH);
      end else begin
         eff_w = row_w;
      end
   end

   assign row_last = (CmpBits'(col_ff) >= (eff_w - CmpBits'(1)));
   assign col_ge_r = (col_ff >= CntBits'(radius));

   always_comb begin
      col_in = col_ff;
      if (accept) begin
         col_in = row_last ? '0 : col_ff + CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   // Pending results of the latest pixel: count left and offset from newest
   logic [1:0]         job_left_ff;
   logic [1:0]         job_left_in;
   logic [1:0]         job_j_ff;
   logic [1:0]         job_j_in;
   logic               job_row_end_ff;
   logic               job_row_end_in;
   logic [1:0]         job_r_ff;
   logic [1:0]         job_r_in;
   logic [2:0]         job_cmin_ff;
   logic [2:0]         job_cmin_in;
   logic               issue;
   logic [LEVEL_BITS:0] occupancy;
   logic [LEVEL_BITS-1:0] fifo_level;
   logic               v1_ff;
   logic               v2;

   assign occupancy  = (LEVEL_BITS + 1)'(fifo_level) + (LEVEL_BITS + 1)'(v1_ff)
                     + (LEVEL_BITS + 1)'(v2);
   assign issue      = (job_left_ff != 2'd0) && (occupancy < (LEVEL_BITS + 1)'(FIFO_DEPTH));
   assign req_tready = (job_left_ff == 2'd0) || ((job_left_ff == 2'd1) && issue);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      job_left_in    = job_left_ff;
      job_j_in       = job_j_ff;
      job_row_end_in = job_row_end_ff;
      job_r_in       = job_r_ff;
      job_cmin_in    = job_cmin_ff;
      if (accept) begin
         job_j_in       = radius;
         job_row_end_in = row_last;
         job_r_in       = radius;
         job_cmin_in    = (col_ff >= CntBits'(4)) ? 3'd4 : 3'(col_ff);
         if (row_last) begin
            job_left_in = radius + 2'd1;
         end else if (col_ge_r) begin
            job_left_in = 2'd1;
         end else begin
            job_left_in = 2'd0;
         end
      end else if (issue) begin
         job_left_in = job_left_ff - 2'd1;
         job_j_in    = job_j_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_left_ff <= 2'd0;
      end else begin
         job_left_ff <= job_left_in;
      end
   end

   always_ff @(posedge clock) begin
      job_j_ff       <= job_j_in;
      job_row_end_ff <= job_row_end_in;
      job_r_ff       <= job_r_in;
      job_cmin_ff    <= job_cmin_in;
   end

   // Taps kept: newest back to kmax = min(j + r, column)
   logic [2:0] reach;
   logic [2:0] kmax;
   div_type    div_sel;

   assign reach = 3'(job_j_ff) + 3'(job_r_ff);
   assign kmax  = (reach < job_cmin_ff) ? reach : job_cmin_ff;

   always_comb begin
      case (kmax)
         3'd1:    div_sel = DIV_BY_2;
         3'd2:    div_sel = DIV_BY_3;
         3'd3:    div_sel = DIV_BY_4;
         3'd4:    div_sel = DIV_BY_5;
         default: div_sel = DIV_BY_2;
      endcase
   end

   // Chain of window taps, newest first, carrying the prefix sum
   logic [PIXEL_BITS-1:0] tap_pix [NUM_TAPS+1];
   logic [SumBits-1:0]    tap_sum [NUM_TAPS+1];

   assign tap_pix[0] = req_tdata[PIXEL_BITS-1:0];
   assign tap_sum[0] = '0;

   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      hbb_tap_cell #(
         .PIXEL_BITS (PIXEL_BITS),
         .SUM_BITS   (SumBits)
      ) u_tap (
         .clock    (clock),
         .shift_en (accept),
         .prev_pix (tap_pix[k]),
         .pix_q    (tap_pix[k+1]),
         .use_tap  (kmax >= 3'(k)),
         .sum_prev (tap_sum[k]),
         .sum_next (tap_sum[k+1])
      );
   end

   // Sum stage
   logic [SumBits-1:0] sum1_ff;
   div_type            div1_ff;
   tag_type            tag1_ff;
   tag_type            tag1_in;

   always_comb begin
      tag1_in.row_end     = job_row_end_ff && (job_j_ff == 2'd0);
      tag1_in.last_of_run = (job_left_ff == 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff <= tap_sum[NUM_TAPS];
      div1_ff <= div_sel;
      tag1_ff <= tag1_in;
   end

   // Divide stage
   logic [RSP_DATA_BITS-1:0] quot2;
   tag_type                  tag2;

   hbb_divider #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_sum    (sum1_ff),
      .in_div    (div1_ff),
      .in_tag    (tag1_ff),
      .out_valid (v2),
      .out_pixel (quot2),
      .out_tag   (tag2)
   );

   // Result queue
   result_type push_data;
   result_type pop_data;

   always_comb begin
      push_data.pixel = quot2;
      push_data.tag   = tag2;
   end

   hbb_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (v2),
      .push_data  (push_data),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (pop_data),
      .level      (fifo_level)
   );

   assign rsp_tdata = pop_data.pixel;
   assign rsp_tlast = pop_data.tag.row_end;
   assign rsp_tuser = pop_data.tag.last_of_run;

endmodule

`default_nettype wire

// File: rtl/hbb_checker.sv
`default_nettype none

`include "horizontal_box_blur_top_defines.svh"

// Port-level checks for the box blur block
module hbb_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [hbb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input wire logic                                rsp_tlast,
   input wire logic                                rsp_tuser
);
   import hbb_pkg::*;

   logic [RSP_DATA_BITS+1:0] rsp_word;

   // Result payload packed for the hold check
   assign rsp_word = {rsp_tdata, rsp_tlast, rsp_tuser};

   // A stalled result holds its payload
   `HBB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word))

   // The last pixel of a row always closes its run of results
   `HBB_ASSERT_SAME(a_row_end_closes_run, rsp_tvalid && rsp_tlast, rsp_tuser)

   // Reset empties the result queue
   `HBB_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid)

   // Reset leaves no pending results, so the input side is open
   `HBB_ASSERT_AFTER_RESET(a_reset_ready, req_tready)

endmodule

bind horizontal_box_blur_top hbb_checker u_checker (.*);

`default_nettype wire
